[rtl/tpsb_pkg.sv]
package tpsb_pkg;

  localparam int TERM_BITS = 40;
  localparam int KEY_BITS  = 3 * TERM_BITS;
  localparam int CAPACITY  = 64;
  localparam int FIFO_DEPTH = 2;

  localparam logic [2:0] ORDER_SPO = 3'd0;
  localparam logic [2:0] ORDER_SOP = 3'd1;
  localparam logic [2:0] ORDER_PSO = 3'd2;
  localparam logic [2:0] ORDER_POS = 3'd3;
  localparam logic [2:0] ORDER_OSP = 3'd4;
  localparam logic [2:0] ORDER_OPS = 3'd5;

  localparam logic [0:0] REG_FIELD_ORDER = 1'b0;

  typedef struct packed {
    logic [TERM_BITS-1:0] subject_term;
    logic [TERM_BITS-1:0] predicate_term;
    logic [TERM_BITS-1:0] object_term;
    logic                 final_triple;
  } in_word_t;

  typedef struct packed {
    logic [TERM_BITS-1:0] key_first;
    logic [TERM_BITS-1:0] key_second;
    logic [TERM_BITS-1:0] key_third;
    logic                 run_end;
  } out_word_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic                last;
  } rec_t;

endpackage

[rtl/tpsb_front.sv]
module tpsb_front #(
  parameter int CAPACITY = tpsb_pkg::CAPACITY
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [0:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  input  logic               push,
  output logic               full,
  input  tpsb_pkg::in_word_t in_word,
  output logic               rec_valid,
  output tpsb_pkg::rec_t     rec,
  input  logic               rec_full
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [2:0]    field_order;
  logic [CW-1:0] count;
  logic          accept;
  logic          last;
  logic [tpsb_pkg::TERM_BITS-1:0] s, p, o;

  assign full      = rec_full;
  assign accept    = push && !rec_full;
  assign rec_valid = accept;
  assign prdata    = (paddr == tpsb_pkg::REG_FIELD_ORDER) ? {29'd0, field_order} : 32'd0;
  assign s = in_word.subject_term;
  assign p = in_word.predicate_term;
  assign o = in_word.object_term;
  assign last = in_word.final_triple || (count == CW'(CAPACITY - 1));

  always_comb begin
    rec.last = last;
    case (field_order)
      tpsb_pkg::ORDER_SOP: rec.key = {s, o, p};
      tpsb_pkg::ORDER_PSO: rec.key = {p, s, o};
      tpsb_pkg::ORDER_POS: rec.key = {p, o, s};
      tpsb_pkg::ORDER_OSP: rec.key = {o, s, p};
      tpsb_pkg::ORDER_OPS: rec.key = {o, p, s};
      default:             rec.key = {s, p, o};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_order <= tpsb_pkg::ORDER_SPO;
      count       <= '0;
    end else begin
      if (psel && penable && pwrite && paddr == tpsb_pkg::REG_FIELD_ORDER) begin
        field_order <= pwdata[2:0];
      end
      if (accept) begin
        count <= last ? '0 : count + CW'(1);
      end
    end
  end

endmodule

[rtl/tpsb_fifo.sv]
module tpsb_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  tpsb_pkg::rec_t wr_data,
  output logic           is_full,
  output logic           rd_valid,
  input  logic           rd_en,
  output tpsb_pkg::rec_t rd_data
);

  localparam int PW = $clog2(tpsb_pkg::FIFO_DEPTH);

  tpsb_pkg::rec_t mem [tpsb_pkg::FIFO_DEPTH];
  logic [PW-1:0] wp, rp;
  logic [PW:0]   fill;
  logic          do_wr, do_rd;

  assign is_full  = fill == (PW+1)'(tpsb_pkg::FIFO_DEPTH);
  assign rd_valid = fill != '0;
  assign rd_data  = mem[rp];
  assign do_wr    = wr_en && !is_full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wp] <= wr_data;
    end
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      fill <= '0;
    end else begin
      if (do_wr) wp <= wp + PW'(1);
      if (do_rd) rp <= rp + PW'(1);
      fill <= fill + (PW+1)'(do_wr) - (PW+1)'(do_rd);
    end
  end

endmodule

[rtl/tpsb_sorter.sv]
module tpsb_sorter #(
  parameter int CAPACITY = tpsb_pkg::CAPACITY
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                rec_valid,
  output logic                rec_take,
  input  tpsb_pkg::rec_t      rec,
  output logic                empty,
  input  logic                pop,
  output tpsb_pkg::out_word_t out_word
);

  localparam int KB = tpsb_pkg::KEY_BITS;
  localparam int TB = tpsb_pkg::TERM_BITS;

  typedef enum logic {FILL, DRAIN} state_t;

  state_t        state;
  logic [KB-1:0] cells [CAPACITY];
  logic [CAPACITY-1:0] valid;
  logic [CAPACITY-1:0] lt;
  logic          head_ok, next_ok, ins, shift_out;

  assign head_ok  = valid[0] && (cells[0] != {KB{1'b1}});
  assign next_ok  = valid[1] && (cells[1] != {KB{1'b1}});
  assign rec_take = state == FILL;
  assign ins      = rec_take && rec_valid;
  assign empty    = !(state == DRAIN && head_ok);
  assign shift_out = pop && !empty;

  assign out_word.key_first  = cells[0][KB-1 -: TB];
  assign out_word.key_second = cells[0][KB-TB-1 -: TB];
  assign out_word.key_third  = cells[0][TB-1:0];
  assign out_word.run_end    = !next_ok;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      lt[i] = !valid[i] || (rec.key < cells[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (ins) begin
        if (i > 0 && lt[i-1]) begin
          cells[i] <= cells[i-1];
        end else if (lt[i]) begin
          cells[i] <= rec.key;
        end
      end else if (shift_out && i < CAPACITY - 1) begin
        cells[i] <= cells[i+1];
      end
    end
    if (rst) begin
      state <= FILL;
      valid <= '0;
    end else begin
      case (state)
        FILL: begin
          if (ins) begin
            valid <= {valid[CAPACITY-2:0], 1'b1};
            if (rec.last) state <= DRAIN;
          end
        end
        DRAIN: begin
          if (!head_ok) begin
            valid <= '0;
            state <= FILL;
          end else if (shift_out) begin
            valid <= {1'b0, valid[CAPACITY-1:1]};
          end
        end
        default: state <= FILL;
      endcase
    end
  end

endmodule

[rtl/triple_permute_sort_buffer.sv]
// channel | handshake               | payload
// input   | push / full             | in_word  (subject, predicate, object, final)
// result  | pop / empty             | out_word (key terms, run_end)
// config  | psel/penable/pwrite     | paddr, pwdata, prdata (field_order)
// One triple accepted per cycle while a batch fills; once the final triple has passed the
// queue and been inserted into the chain, one sorted word shows per cycle while pop is held,
// then the chain rearms. Insertion into the sorted cell chain sets the fill rate; while
// draining the queue takes two more triples, then full stays high until the chain rearms.
// Synchronous reset empties the chain and the queue; the store needs no clearing pass.
module triple_permute_sort_buffer #(
  parameter int CAPACITY = tpsb_pkg::CAPACITY
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [0:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                push,
  output logic                full,
  input  tpsb_pkg::in_word_t  in_word,
  output logic                empty,
  input  logic                pop,
  output tpsb_pkg::out_word_t out_word
);

  logic           f_valid, q_full, q_valid, q_take;
  tpsb_pkg::rec_t f_rec, q_rec;

  assign pready = 1'b1;

  tpsb_front #(.CAPACITY(CAPACITY)) u_front (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
    .push, .full, .in_word,
    .rec_valid(f_valid), .rec(f_rec), .rec_full(q_full)
  );

  tpsb_fifo u_fifo (
    .clk, .rst, .wr_en(f_valid), .wr_data(f_rec), .is_full(q_full),
    .rd_valid(q_valid), .rd_en(q_take), .rd_data(q_rec)
  );

  tpsb_sorter #(.CAPACITY(CAPACITY)) u_sorter (
    .clk, .rst, .rec_valid(q_valid), .rec_take(q_take), .rec(q_rec),
    .empty, .pop, .out_word
  );

endmodule

[rtl/tpsb_checker.sv]
module tpsb_checker (
  input logic                clk,
  input logic                rst,
  input logic                pready,
  input logic                empty,
  input logic                pop,
  input tpsb_pkg::out_word_t out_word
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result not empty after reset");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_word)))
    else $error("waiting word changed");

  a_run_end: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && out_word.run_end) |=> empty)
    else $error("word after run_end");

endmodule

bind triple_permute_sort_buffer tpsb_checker u_tpsb_checker (
  .clk, .rst, .pready, .empty, .pop, .out_word
);
